/* design/assert_macros.svh */
// Assertion helper macros for the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("check failed: property violated");

// Boolean condition must never be seen outside reset.
`define CHK_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("check failed: forbidden condition seen");

`endif

/* design/i2crb_pkg.sv */
// Shared types and constants of the I2C register bank.
// No dependencies.
package i2crb_pkg;

	localparam logic [2:0] CMD_RX     = 3'd0;
	localparam logic [2:0] CMD_RD     = 3'd1;
	localparam logic [2:0] CMD_FIN    = 3'd2;
	localparam logic [2:0] CMD_POLL   = 3'd3;
	localparam logic [2:0] CMD_SAMPLE = 3'd4;
	localparam logic [2:0] CMD_LOCAL  = 3'd5;

	// operations handed from front to back
	localparam logic [1:0] OP_NOP   = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_POLL  = 2'd3;

	localparam int QUEUE_DEPTH = 2;
	localparam int GRP_SIZE    = 16;

	localparam logic [7:0] VERSION_RESET_IDX = 8'h00;
	localparam logic [7:0] GPIO_RESET_IDX    = 8'h01;
	localparam logic [7:0] VERSION_RESET_VAL = 8'h01;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] data_byte;
		logic [7:0] local_index;
		logic [4:0] gpio_levels;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       change_valid;
		logic [7:0] change_index;
		logic [7:0] change_value;
	} out_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] idx;
		logic [7:0] data;
		logic       mark;
	} op_t;

	typedef struct packed {
		logic [7:0] ver_idx;
		logic [7:0] gpio_idx;
	} cfg_t;

endpackage

/* design/i2crb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module i2crb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/i2crb_fifo.sv */
// Short operation queue between front and back.
// Depends on i2crb_pkg (op_t).
module i2crb_fifo import i2crb_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output op_t  pop_op,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t           slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign pop_op = slot_q[rd_q];

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_op;
		end
	end

endmodule

/* design/i2crb_front.sv */
// Front end: accepts command beats, tracks pointer and transfer state,
// resolves each command into a bank operation. Depends on i2crb_pkg.
module i2crb_front import i2crb_pkg::*; #(
	parameter int REG_COUNT  = 256,
	parameter int GPIO_COUNT = 5
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	input  cfg_t     cfg,
	output logic     push,
	output op_t      push_op,
	input  logic     q_full
);

	localparam logic [7:0] GPIO_MASK = 8'((1 << GPIO_COUNT) - 1);

	logic [7:0] ptr_q;
	logic       xfer_q;
	logic [7:0] ptr_d;
	logic       xfer_d;
	logic       accept;

	function automatic logic in_bank(input logic [7:0] idx);
		return ({1'b0, idx} < 9'(REG_COUNT));
	endfunction

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept;

	always_comb begin
		ptr_d   = ptr_q;
		xfer_d  = xfer_q;
		push_op = '{kind: OP_NOP, idx: 8'h00, data: 8'h00, mark: 1'b0};
		case (in_data.cmd)
			CMD_RX: begin
				if (!xfer_q) begin
					ptr_d  = in_data.data_byte;
					xfer_d = 1'b1;
				end else begin
					if (ptr_q != cfg.ver_idx && ptr_q != cfg.gpio_idx && in_bank(ptr_q)) begin
						push_op = '{kind: OP_WRITE, idx: ptr_q, data: in_data.data_byte,
							mark: 1'b1};
					end
					ptr_d = ptr_q + 8'd1;
				end
			end
			CMD_RD: begin
				if (in_bank(ptr_q)) begin
					push_op = '{kind: OP_READ, idx: ptr_q, data: 8'h00, mark: 1'b0};
				end
				ptr_d = ptr_q + 8'd1;
			end
			CMD_FIN: begin
				xfer_d = 1'b0;
			end
			CMD_POLL: begin
				push_op = '{kind: OP_POLL, idx: 8'h00, data: 8'h00, mark: 1'b0};
			end
			CMD_SAMPLE: begin
				if (in_bank(cfg.gpio_idx)) begin
					push_op = '{kind: OP_WRITE, idx: cfg.gpio_idx,
						data: {3'b000, in_data.gpio_levels} & GPIO_MASK, mark: 1'b0};
				end
			end
			CMD_LOCAL: begin
				if (in_bank(in_data.local_index)) begin
					push_op = '{kind: OP_WRITE, idx: in_data.local_index,
						data: in_data.data_byte, mark: 1'b1};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= 8'h00;
			xfer_q <= 1'b0;
		end else if (accept) begin
			ptr_q  <= ptr_d;
			xfer_q <= xfer_d;
		end
	end

endmodule

/* design/i2crb_back.sv */
// Back end: executes bank operations on the register RAM, keeps changed
// and written flags, two-level priority search for poll, output register.
// Depends on i2crb_pkg and i2crb_ram.
module i2crb_back import i2crb_pkg::*; #(
	parameter int REG_COUNT = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  op_t       q_op,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int AW   = $clog2(REG_COUNT);
	localparam int SW   = $clog2(GRP_SIZE);
	localparam int GW   = (AW > SW) ? AW - SW : 1;
	localparam int NGRP = 2 ** GW;
	localparam int FD   = NGRP * GRP_SIZE;
	localparam int FW   = GW + SW;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_PSUB  = 2'd2;
	localparam logic [1:0] ST_PDATA = 2'd3;

	logic [1:0]          state_q;
	logic [1:0]          state_d;
	logic [FD-1:0]       flags_q;
	logic [FD-1:0]       written_q;
	logic [GW-1:0]       grp_q;
	logic [FW-1:0]       pidx_q;
	logic [7:0]          dflt_q;
	logic                use_ram_q;
	logic                out_valid_q;
	out_item_t           out_q;

	logic                out_take;
	logic                start;
	logic [AW-1:0]       op_addr;
	logic [FW-1:0]       op_fidx;
	logic [NGRP-1:0]     grp_any;
	logic                any_flag;
	logic [GW-1:0]       grp_sel;
	logic [GRP_SIZE-1:0] grp_bits;
	logic [SW-1:0]       sub_sel;
	logic [FW-1:0]       psub_idx;
	logic                load_out;
	out_item_t           out_d;

	logic                ram_we;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [7:0]          ram_rdata;

	// unwritten entries read as their reset value
	function automatic logic [7:0] reset_val(input logic [AW-1:0] a);
		return (8'(a) == VERSION_RESET_IDX) ? VERSION_RESET_VAL : 8'h00;
	endfunction

	assign out_take = out_valid_q && !out_stall;
	// output register is free for the whole op once it starts
	assign start    = (state_q == ST_IDLE) && !q_empty && (!out_valid_q || out_take);
	assign q_pop    = start;
	assign op_addr  = q_op.idx[AW-1:0];
	assign op_fidx  = FW'(op_addr);

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_any[g] = |flags_q[g*GRP_SIZE +: GRP_SIZE];
		end
	end

	assign any_flag = |grp_any;

	always_comb begin
		grp_sel = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_any[g]) begin
				grp_sel = GW'(g);
			end
		end
	end

	assign grp_bits = flags_q[{grp_q, {SW{1'b0}}} +: GRP_SIZE];

	always_comb begin
		sub_sel = '0;
		for (int s = GRP_SIZE - 1; s >= 0; s--) begin
			if (grp_bits[s]) begin
				sub_sel = SW'(s);
			end
		end
	end

	assign psub_idx = {grp_q, sub_sel};

	assign ram_we    = start && (q_op.kind == OP_WRITE);
	assign ram_re    = (start && (q_op.kind == OP_READ)) || (state_q == ST_PSUB);
	assign ram_raddr = (state_q == ST_PSUB) ? psub_idx[AW-1:0] : op_addr;

	i2crb_ram #(
		.WIDTH(8),
		.DEPTH(REG_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(op_addr),
		.wdata(q_op.data),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		out_d    = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (q_op.kind)
						OP_READ: begin
							state_d = ST_READ;
						end
						OP_POLL: begin
							if (any_flag) begin
								state_d = ST_PSUB;
							end else begin
								load_out = 1'b1;
							end
						end
						OP_NOP, OP_WRITE: begin
							load_out = 1'b1;
						end
						default: begin
							load_out = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				load_out        = 1'b1;
				out_d.read_byte = use_ram_q ? ram_rdata : dflt_q;
				state_d         = ST_IDLE;
			end
			ST_PSUB: begin
				state_d = ST_PDATA;
			end
			ST_PDATA: begin
				load_out           = 1'b1;
				out_d.change_valid = 1'b1;
				out_d.change_index = 8'(pidx_q);
				out_d.change_value = ram_rdata;
				state_d            = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			flags_q     <= '0;
			written_q   <= '0;
		end else begin
			state_q <= state_d;
			if (out_take) begin
				out_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end
			if (ram_we) begin
				written_q[op_fidx] <= 1'b1;
				if (q_op.mark) begin
					flags_q[op_fidx] <= 1'b1;
				end
			end
			if (state_q == ST_PSUB) begin
				flags_q[psub_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			grp_q     <= grp_sel;
			use_ram_q <= written_q[op_fidx];
			dflt_q    <= reset_val(op_addr);
		end
		if (state_q == ST_PSUB) begin
			pidx_q <= psub_idx;
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* design/i2c_register_bank_with_change_flags.sv */
// Top level of the I2C target register bank: APB config registers,
// front end, operation queue, back end. Depends on i2crb_pkg and submodules.
//
//  channel | direction | beat type   | handshake
//  --------+-----------+-------------+----------------------------------
//  in      | into      | in_item_t   | in_valid / in_stall
//  out     | out of    | out_item_t  | out_valid / out_stall
//  apb     | into      | 32-bit word | psel, penable, pwrite, pready = 1
//
// Front decodes one beat per cycle, unless the queue is full, into a 2-deep queue.
// Back steps per beat: nop/write load the output directly, read goes through a
// registered RAM read, poll through group search, in-group search and RAM read,
// or loads the output directly when no flag is set. Reset clears pointer,
// transfer state, changed and written flags at once; no clearing pass,
// unwritten registers read their reset value. out_stall holds the output
// register; the back end waits, then the queue fills and in_stall rises.
module i2c_register_bank_with_change_flags import i2crb_pkg::*; #(
	parameter int REG_COUNT  = 256,
	parameter int GPIO_COUNT = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic REG_VERSION = 1'b0;
	localparam logic REG_GPIO    = 1'b1;

	cfg_t cfg_q;
	logic cfg_wr;
	logic push;
	op_t  push_op;
	logic q_full;
	logic q_pop;
	op_t  q_op;
	logic q_empty;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ver_idx  <= VERSION_RESET_IDX;
			cfg_q.gpio_idx <= GPIO_RESET_IDX;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_VERSION: cfg_q.ver_idx  <= pwdata[7:0];
				REG_GPIO:    cfg_q.gpio_idx <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_VERSION: prdata = {24'h000000, cfg_q.ver_idx};
			REG_GPIO:    prdata = {24'h000000, cfg_q.gpio_idx};
			default:     prdata = 32'h00000000;
		endcase
	end

	i2crb_front #(
		.REG_COUNT (REG_COUNT),
		.GPIO_COUNT(GPIO_COUNT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data (in_data),
		.cfg     (cfg_q),
		.push    (push),
		.push_op (push_op),
		.q_full  (q_full)
	);

	i2crb_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(push_op),
		.full   (q_full),
		.pop    (q_pop),
		.pop_op (q_op),
		.empty  (q_empty)
	);

	i2crb_back #(
		.REG_COUNT(REG_COUNT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_op     (q_op),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

/* design/i2crb_checker.sv */
// Port-level checker for the register bank, bound to the top level.
// Depends on i2crb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2crb_checker import i2crb_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input out_item_t   out_data,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);

	// stalled result beat holds
	`CHK_ASSERT(a_out_hold, clk, arst_n,
		out_valid && out_stall |=> out_valid && $stable(out_data))

	// a result is either a read or a poll, never both
	`CHK_NEVER(a_read_vs_change, clk, arst_n,
		out_valid && out_data.change_valid && out_data.read_byte != 8'h00)

	// empty poll and other commands leave change fields zero
	`CHK_ASSERT(a_no_change_zero, clk, arst_n,
		out_valid && !out_data.change_valid |->
		out_data.change_index == 8'h00 && out_data.change_value == 8'h00)

	// config write is visible on readback in the next cycle
	`CHK_ASSERT(a_cfg_readback, clk, arst_n,
		psel && penable && pwrite && pready |=>
		!(psel && !pwrite && paddr[2] == $past(paddr[2])) ||
		(prdata[7:0] == $past(pwdata[7:0]) && prdata[31:8] == 24'h000000))

endmodule

bind i2c_register_bank_with_change_flags i2crb_checker u_chk (.*);

/* tb/sv/i2c_register_bank_with_change_flags_tb.sv */
// Self-checking bench for the I2C target register bank: bus beats in, result beats out,
// with APB index writes between phases and a behavioral model of the bank.
// Depends on i2crb_pkg and i2c_register_bank_with_change_flags.
module i2c_register_bank_with_change_flags_tb;
	import i2crb_pkg::*;

	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;
	localparam logic [2:0] ADDR_VERSION_IDX = 3'd0;
	localparam logic [2:0] ADDR_GPIO_IDX = 3'd4;
	localparam out_item_t NO_RESULT = '0;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		in_item_t  beat;
		bit        known;
		out_item_t result;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// model state
	logic [7:0] bank [256];
	bit         changed [256];
	logic [7:0] bus_ptr;
	bit         bus_active;
	logic [7:0] ver_idx;
	logic [7:0] gpio_idx;

	out_item_t expected_results [$];
	dir_row_t  dir_rows [$];
	int        mismatches = 0;
	bit        in_calm = 1'b0;
	bit        out_calm = 1'b0;

	i2c_register_bank_with_change_flags dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	function automatic void flag_error(string msg);
		mismatches++;
		if (mismatches <= 10) $display("%s", msg);
	endfunction

	function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (act_v !== exp_v)
			flag_error($sformatf("%s mismatch: expected %02h, got %02h", name, exp_v, act_v));
	endfunction

	function automatic out_item_t predict_bank(in_item_t b);
		out_item_t r;
		int i;
		r = '0;
		case (b.cmd)
			CMD_RX: begin
				if (!bus_active) begin
					bus_ptr = b.data_byte;
					bus_active = 1'b1;
				end else begin
					if (bus_ptr != ver_idx && bus_ptr != gpio_idx) begin
						bank[bus_ptr] = b.data_byte;
						changed[bus_ptr] = 1'b1;
					end
					bus_ptr = bus_ptr + 8'd1;
				end
			end
			CMD_RD: begin
				r.read_byte = bank[bus_ptr];
				bus_ptr = bus_ptr + 8'd1;
			end
			CMD_FIN: bus_active = 1'b0;
			CMD_POLL: begin
				for (i = 0; i < 256 && !r.change_valid; i++) begin
					if (changed[i]) begin
						changed[i] = 1'b0;
						r.change_valid = 1'b1;
						r.change_index = i[7:0];
						r.change_value = bank[i];
					end
				end
			end
			// sampled levels land even on a moved index; no flag
			CMD_SAMPLE: bank[gpio_idx] = {3'b000, b.gpio_levels};
			CMD_LOCAL: begin
				bank[b.local_index] = b.data_byte;
				changed[b.local_index] = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic in_item_t rand_beat();
		in_item_t b;
		b.cmd = 3'($urandom_range(0, 7));
		b.data_byte = 8'($urandom_range(0, 255));
		b.local_index = 8'($urandom_range(0, 255));
		b.gpio_levels = 5'($urandom_range(0, 31));
		return b;
	endfunction

	// bias toward read-only slots and the wrap point
	function automatic logic [7:0] pick_index();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) return ver_idx;
		if (r < 35) return gpio_idx;
		if (r < 45) return 8'hFE;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void add_row(logic [2:0] c, logic [7:0] d, logic [7:0] li,
			logic [4:0] g, bit known = 1'b0, out_item_t res = '0);
		dir_row_t row;
		row.beat = '{cmd: c, data_byte: d, local_index: li, gpio_levels: g};
		row.known = known;
		row.result = res;
		dir_rows.push_back(row);
	endfunction

	// returns in the step of the accepting edge, valid still high
	task automatic send_beat(in_item_t beat, bit known = 1'b0, out_item_t typed = '0);
		int gap;
		out_item_t pred;
		if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
		gap = in_calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pred = predict_bank(beat);
		expected_results.push_back(known ? typed : pred);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {24'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("index readback", value, prdata[7:0]);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_VERSION_IDX) ver_idx = value;
		else gpio_idx = value;
	endtask

	task automatic run_random(int n);
		int sent;
		int len;
		int k;
		int r;
		bit writing;
		in_item_t b;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			b = rand_beat();
			if (r < 55) begin
				// bus transfer: pointer byte, then a run of mostly writes or mostly reads
				b.cmd = CMD_RX;
				b.data_byte = pick_index() - 8'($urandom_range(0, 3));
				send_beat(b);
				len = $urandom_range(1, 8);
				writing = 1'($urandom_range(0, 1));
				for (k = 0; k < len; k++) begin
					b = rand_beat();
					b.cmd = ($urandom_range(0, 9) == 0) ? (writing ? CMD_RD : CMD_RX)
						: (writing ? CMD_RX : CMD_RD);
					send_beat(b);
				end
				sent += len + 1;
				if ($urandom_range(0, 9) != 0) begin
					b = rand_beat();
					b.cmd = CMD_FIN;
					send_beat(b);
					sent++;
				end
			end else begin
				if (r < 70) b.cmd = CMD_POLL;
				else if (r < 78) b.cmd = CMD_SAMPLE;
				else if (r < 88) begin
					b.cmd = CMD_LOCAL;
					b.local_index = pick_index();
				end
				send_beat(b);
				if (b.cmd <= CMD_LOCAL) sent++;
			end
		end
	endtask

	task automatic run_phase(logic [7:0] v, logic [7:0] g, int n);
		drain();
		apb_write(ADDR_VERSION_IDX, v);
		apb_write(ADDR_GPIO_IDX, g);
		run_random(n);
	endtask

	// result side: random stall per beat, compare with oldest expectation
	initial begin
		int stall_left;
		out_item_t e;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					flag_error($sformatf("unexpected result beat %h", out_data));
				end else begin
					e = expected_results.pop_front();
					check_field("read_byte", e.read_byte, out_data.read_byte);
					check_field("change_valid", {7'b0, e.change_valid},
						{7'b0, out_data.change_valid});
					check_field("change_index", e.change_index, out_data.change_index);
					check_field("change_value", e.change_value, out_data.change_value);
				end
				if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
				stall_left = out_calm ? 0 : $urandom_range(0, 11);
			end
			out_stall <= (stall_left > 0);
			if (stall_left > 0) stall_left--;
		end
	end

	// watchdog on cycles with no beat moving on either channel
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("i2c_register_bank_with_change_flags regression: fail");
				$finish;
			end
		end
	end

	initial begin
		int k;
		for (k = 0; k < 256; k++) begin
			bank[k] = 8'h00;
			changed[k] = 1'b0;
		end
		bank[VERSION_RESET_IDX] = VERSION_RESET_VAL;
		bus_ptr = 8'h00;
		bus_active = 1'b0;
		ver_idx = VERSION_RESET_IDX;
		gpio_idx = GPIO_RESET_IDX;

		add_row(CMD_POLL, 8'h00, 8'h00, 5'h00, 1'b1, NO_RESULT);
		add_row(CMD_RD, 8'hFF, 8'hFF, 5'h1F, 1'b1, out_item_t'{8'h01, 1'b0, 8'h00, 8'h00});
		add_row(CMD_RD, 8'h00, 8'h00, 5'h00, 1'b1, NO_RESULT);
		add_row(CMD_SAMPLE, 8'h00, 8'h00, 5'h1F, 1'b1, NO_RESULT);
		add_row(CMD_FIN, 8'hFF, 8'hFF, 5'h00, 1'b1, NO_RESULT);
		add_row(CMD_RX, 8'hFE, 8'h00, 5'h00, 1'b1, NO_RESULT);
		add_row(CMD_RX, 8'hAA, 8'h00, 5'h00, 1'b1, NO_RESULT);
		add_row(CMD_RX, 8'h55, 8'h00, 5'h00, 1'b1, NO_RESULT);
		add_row(CMD_RX, 8'h77, 8'h00, 5'h00, 1'b1, NO_RESULT); // lands on version
		add_row(CMD_RX, 8'h88, 8'h00, 5'h00, 1'b1, NO_RESULT); // lands on gpio input
		add_row(CMD_RX, 8'h00, 8'h00, 5'h00, 1'b1, NO_RESULT);
		add_row(CMD_FIN, 8'h00, 8'h00, 5'h00, 1'b1, NO_RESULT);
		add_row(CMD_RX, 8'hFE, 8'h00, 5'h00, 1'b1, NO_RESULT);
		add_row(CMD_RD, 8'h00, 8'h00, 5'h00);
		add_row(CMD_RD, 8'h00, 8'h00, 5'h00);
		add_row(CMD_RD, 8'h00, 8'h00, 5'h00);
		add_row(CMD_RD, 8'h00, 8'h00, 5'h00);
		add_row(CMD_POLL, 8'h00, 8'h00, 5'h00);
		add_row(CMD_POLL, 8'h00, 8'h00, 5'h00);
		add_row(CMD_POLL, 8'h00, 8'h00, 5'h00);
		add_row(CMD_POLL, 8'h00, 8'h00, 5'h00, 1'b1, NO_RESULT);
		add_row(CMD_LOCAL, 8'hFF, 8'h00, 5'h00, 1'b1, NO_RESULT); // ignores read-only
		add_row(CMD_POLL, 8'h00, 8'h00, 5'h00);
		add_row(CMD_SPARE6, 8'hFF, 8'hFF, 5'h1F, 1'b1, NO_RESULT);
		add_row(CMD_SPARE7, 8'hFF, 8'hFF, 5'h1F, 1'b1, NO_RESULT);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[row_i])
			send_beat(dir_rows[row_i].beat, dir_rows[row_i].known, dir_rows[row_i].result);

		run_phase(8'hFF, 8'h00, 270);
		run_phase(8'h07, 8'h07, 270);
		run_phase(8'h00, 8'hFF, 270);
		run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 270);
		run_phase(VERSION_RESET_IDX, GPIO_RESET_IDX, 270);

		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("i2c_register_bank_with_change_flags regression: pass");
		else
			$display("i2c_register_bank_with_change_flags regression: fail");
		$finish;
	end

endmodule
